// ===== src/osrs_pkg.sv =====
// Package with the item types, fp32 constants and shared fp32 helper functions.
`timescale 1ns / 1ps
`default_nettype none

package osrs_pkg;

   typedef struct packed {
      logic [31:0] score_bits;
      logic        last_in_row;
   } req_type;

   typedef struct packed {
      logic [31:0] exp_of_max_bits;
      logic [31:0] denominator_bits;
   } rsp_type;

   localparam logic [31:0] NEG_INF     = 32'hFF80_0000;
   localparam logic [31:0] POS_INF     = 32'h7F80_0000;
   localparam logic [31:0] POS_ZERO    = 32'h0000_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

   // exp saturates above 89.0 and flushes to zero below -104.0.
   localparam logic [31:0] EXP_HI_LIMIT = 32'h42B2_0000;
   localparam logic [31:0] EXP_LO_LIMIT = 32'hC2D0_0000;

   // Fixed-point layout of the exp unit: log2 domain with 60 fraction bits.
   localparam int EXP_FRAC  = 60;
   localparam int EXP_STEPS = 56;
   localparam int STEP_W    = $clog2(EXP_STEPS);

   localparam logic [191:0] LOG2E_WIDE =
      192'd14426950408889634073599246810019 * (192'd1 << EXP_FRAC) /
      192'd10000000000000000000000000000000;
   localparam logic [EXP_FRAC:0] LOG2E_FIX = LOG2E_WIDE[EXP_FRAC:0];

   typedef enum logic [1:0] {
      FOP_ADD,
      FOP_SUB,
      FOP_MUL
   } fop_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SUB_OLD,
      DP_ZERO_SCALED,
      DP_EXP_DIFF,
      DP_MUL,
      DP_TAKE_SCALED,
      DP_SUB_NEW,
      DP_ADD,
      DP_COMMIT,
      DP_EXP_MAX,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic fpu_done;
      logic exp_done;
      logic row_started;
      logic last_in_row;
   } dp_status_type;

   typedef struct packed {
      logic signed [11:0] e;
      logic [63:0]        m;
   } norm_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   // Ordered compare for two values that are not NaN and not equal.
   function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
      if (a[31] != b[31]) begin
         return !a[31];
      end
      if (!a[31]) begin
         return a[30:0] > b[30:0];
      end
      return a[30:0] < b[30:0];
   endfunction

   // IEEE maxnum: a NaN operand loses, plus zero beats minus zero.
   function automatic logic [31:0] fp_maxnum(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a)) begin
         return is_nan(b) ? a : b;
      end
      if (is_nan(b)) begin
         return a;
      end
      if ((a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))) begin
         return a[31] ? b : a;
      end
      return fp_greater(a, b) ? a : b;
   endfunction

   // Shift the leading one up to bit 63 and adjust the exponent to match.
   function automatic norm_type fp_norm(input logic signed [11:0] e, input logic [63:0] m);
      norm_type   r;
      logic [6:0] z;
      logic       hit;
      z   = 7'd0;
      hit = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!hit) begin
            if (m[i]) begin
               hit = 1'b1;
            end else begin
               z = z + 7'd1;
            end
         end
      end
      r.m = m << z;
      r.e = e - $signed({5'd0, z});
      return r;
   endfunction

   // Round to nearest even and pack. The value is m / 2^63 * 2^e, with m
   // normalized or zero; sticky stands for bits below m.
   function automatic logic [31:0] fp_pack(input logic sign, input logic signed [11:0] e,
                                           input logic [63:0] m, input logic sticky);
      logic signed [12:0] be;
      logic signed [12:0] under;
      logic [6:0]         sh;
      logic [127:0]       w;
      logic [63:0]        m2;
      logic               st;
      logic               rnd;
      logic [7:0]         bem1;
      logic [31:0]        r;
      be = {e[11], e} + 13'sd127;
      if (m == 64'd0) begin
         return {sign, 31'd0};
      end
      if (be >= 13'sd255) begin
         return {sign, POS_INF[30:0]};
      end
      if (be < 13'sd1) begin
         under = 13'sd1 - be;
         sh    = (under > 13'sd65) ? 7'd65 : under[6:0];
         bem1  = 8'd0;
      end else begin
         sh    = 7'd0;
         bem1  = be[7:0] - 8'd1;
      end
      w   = {m, 64'd0} >> sh;
      m2  = w[127:64];
      st  = sticky | (|w[63:0]) | (|m2[38:0]);
      rnd = m2[39] & (st | m2[40]);
      r   = {1'b0, bem1, 23'd0} + {8'd0, m2[63:40]} + {31'd0, rnd};
      return {sign, r[30:0]};
   endfunction

   // log2(1 + 2^-j) in the exp unit's fixed point, by repeated squaring.
   function automatic logic [EXP_FRAC-1:0] log2_1p(input int j);
      logic [127:0] y;
      logic [127:0] two;
      logic [63:0]  r;
      y   = (128'd1 << EXP_FRAC) + (128'd1 << (EXP_FRAC - j));
      two = 128'd2 << EXP_FRAC;
      r   = 64'd0;
      for (int b = 0; b < EXP_FRAC + 2; b++) begin
         y = (y * y) >> EXP_FRAC;
         r = r << 1;
         if (y >= two) begin
            r = r | 64'd1;
            y = y >> 1;
         end
      end
      return r[EXP_FRAC+1:2];
   endfunction

endpackage

`default_nettype wire

// ===== src/osrs_fpu.sv =====
// Two-stage fp32 add, subtract and multiply unit with round to nearest even.
`timescale 1ns / 1ps
`default_nettype none

module osrs_fpu (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire osrs_pkg::fop_type op,
   input  wire logic [31:0]     a,
   input  wire logic [31:0]     b,
   output logic                 done,
   output logic [31:0]          result
);

   logic               s1_valid_ff;
   logic               done_ff;
   logic               spec_ff, spec_in;
   logic [31:0]        spec_val_ff, spec_val_in;
   logic               sign_ff, sign_in;
   logic signed [11:0] e_ff, e_in;
   logic [63:0]        m_ff, m_in;
   logic [31:0]        result_ff;

   logic [31:0]  bx, big, little;
   logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [7:0]   eb_big, eb_small, ea, eb, d;
   logic [23:0]  m_big, m_small, ma, mb;
   logic [63:0]  big_m, small_m, sum_m;
   logic [127:0] w;
   logic [47:0]  prod;
   osrs_pkg::norm_type nrm;

   always_comb begin
      bx      = (op == osrs_pkg::FOP_SUB) ? {~b[31], b[30:0]} : b;
      a_nan   = osrs_pkg::is_nan(a);
      b_nan   = osrs_pkg::is_nan(b);
      a_inf   = (a[30:0] == osrs_pkg::POS_INF[30:0]);
      b_inf   = (b[30:0] == osrs_pkg::POS_INF[30:0]);
      a_zero  = (a[30:0] == 31'd0);
      b_zero  = (b[30:0] == 31'd0);

      if (b[30:0] > a[30:0]) begin
         big    = bx;
         little = a;
      end else begin
         big    = a;
         little = bx;
      end
      eb_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_small = (little[30:23] == 8'd0) ? 8'd1 : little[30:23];
      m_big    = {big[30:23] != 8'd0, big[22:0]};
      m_small  = {little[30:23] != 8'd0, little[22:0]};
      d        = eb_big - eb_small;
      big_m    = {1'b0, m_big, 39'd0};
      w        = {1'b0, m_small, 39'd0, 64'd0} >> d;
      small_m  = w[127:64] | {63'd0, |w[63:0]};
      sum_m    = (big[31] ^ little[31]) ? (big_m - small_m) : (big_m + small_m);

      ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma   = {a[30:23] != 8'd0, a[22:0]};
      mb   = {b[30:23] != 8'd0, b[22:0]};
      prod = ma * mb;

      spec_in     = 1'b0;
      spec_val_in = osrs_pkg::DEFAULT_NAN;
      sign_in     = 1'b0;
      e_in        = 12'sd0;
      m_in        = 64'd0;

      case (op)
         osrs_pkg::FOP_ADD, osrs_pkg::FOP_SUB: begin
            sign_in = (sum_m == 64'd0) ? (a[31] & bx[31]) : big[31];
            e_in    = $signed({4'd0, eb_big}) - 12'sd126;
            m_in    = sum_m;
            if (a_nan) begin
               spec_in     = 1'b1;
               spec_val_in = a | osrs_pkg::QUIET_BIT;
            end else if (b_nan) begin
               spec_in     = 1'b1;
               spec_val_in = b | osrs_pkg::QUIET_BIT;
            end else if (a_inf && b_inf) begin
               spec_in     = 1'b1;
               spec_val_in = (a[31] == bx[31]) ? a : osrs_pkg::DEFAULT_NAN;
            end else if (a_inf) begin
               spec_in     = 1'b1;
               spec_val_in = a;
            end else if (b_inf) begin
               spec_in     = 1'b1;
               spec_val_in = bx;
            end
         end
         osrs_pkg::FOP_MUL: begin
            sign_in = a[31] ^ b[31];
            e_in    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd253;
            m_in    = {prod, 16'd0};
            if (a_nan) begin
               spec_in     = 1'b1;
               spec_val_in = a | osrs_pkg::QUIET_BIT;
            end else if (b_nan) begin
               spec_in     = 1'b1;
               spec_val_in = b | osrs_pkg::QUIET_BIT;
            end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
               spec_in     = 1'b1;
               spec_val_in = osrs_pkg::DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
               spec_in     = 1'b1;
               spec_val_in = {sign_in, osrs_pkg::POS_INF[30:0]};
            end
         end
         default: begin
            spec_in     = 1'b1;
            spec_val_in = osrs_pkg::DEFAULT_NAN;
         end
      endcase

      nrm = osrs_pkg::fp_norm(e_ff, m_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         done_ff     <= s1_valid_ff;
      end
      if (start) begin
         spec_ff     <= spec_in;
         spec_val_ff <= spec_val_in;
         sign_ff     <= sign_in;
         e_ff        <= e_in;
         m_ff        <= m_in;
      end
      if (s1_valid_ff) begin
         result_ff <= spec_ff ? spec_val_ff
                              : osrs_pkg::fp_pack(sign_ff, nrm.e, nrm.m, 1'b0);
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== src/osrs_exp.sv =====
// Iterative fp32 exp unit: scaling by log2(e), then shift-and-add steps in fixed point.
`timescale 1ns / 1ps
`default_nettype none

module osrs_exp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] x,
   output logic             done,
   output logic [31:0]      result
);

   localparam int LO_W = 30;
   localparam int HI_W = osrs_pkg::EXP_FRAC + 1 - LO_W;
   localparam int T_W  = osrs_pkg::EXP_FRAC + 9;

   typedef enum logic [2:0] {
      E_IDLE,
      E_MLO,
      E_MHI,
      E_SHIFT,
      E_ITER,
      E_PACK
   } phase_type;

   phase_type                        phase_ff;
   logic                             done_ff;
   logic [31:0]                      x_ff;
   logic [31:0]                      res_ff;
   logic [24+LO_W-1:0]               plo_ff;
   logic [24+HI_W-1:0]               phi_ff;
   logic signed [8:0]                k_ff;
   logic [osrs_pkg::EXP_FRAC-1:0]    f_ff;
   logic [63:0]                      y_ff;
   logic [osrs_pkg::STEP_W-1:0]      j_ff;

   logic [osrs_pkg::EXP_FRAC-1:0]    tbl [osrs_pkg::EXP_STEPS];

   for (genvar g = 0; g < osrs_pkg::EXP_STEPS; g++) begin : g_tbl
      assign tbl[g] = osrs_pkg::log2_1p(g + 1);
   end

   logic [7:0]                       be_eff;
   logic [23:0]                      mant;
   logic [24+osrs_pkg::EXP_FRAC:0]   prod;
   logic [7:0]                       sh;
   logic [24+osrs_pkg::EXP_FRAC:0]   mag;
   logic [T_W-1:0]                   t;
   logic [osrs_pkg::STEP_W-1:0]      step;
   logic                             take;

   always_comb begin
      be_eff = (x_ff[30:23] == 8'd0) ? 8'd1 : x_ff[30:23];
      mant   = {x_ff[30:23] != 8'd0, x_ff[22:0]};
      prod   = {{HI_W{1'b0}}, plo_ff} + ({{LO_W{1'b0}}, phi_ff} << LO_W);
      sh     = 8'd150 - be_eff;
      mag    = prod >> sh;
      t      = x_ff[31] ? (~mag[T_W-1:0] + 1'b1) : mag[T_W-1:0];
      step   = j_ff + 1'b1;
      take   = (f_ff >= tbl[j_ff]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            E_IDLE: begin
               if (start) begin
                  x_ff     <= x;
                  phase_ff <= E_MLO;
               end
            end
            E_MLO: begin
               plo_ff <= mant * osrs_pkg::LOG2E_FIX[LO_W-1:0];
               if (osrs_pkg::is_nan(x_ff)) begin
                  res_ff   <= x_ff | osrs_pkg::QUIET_BIT;
                  done_ff  <= 1'b1;
                  phase_ff <= E_IDLE;
               end else if (!x_ff[31] && (x_ff[30:0] > osrs_pkg::EXP_HI_LIMIT[30:0])) begin
                  res_ff   <= osrs_pkg::POS_INF;
                  done_ff  <= 1'b1;
                  phase_ff <= E_IDLE;
               end else if (x_ff[31] && (x_ff[30:0] > osrs_pkg::EXP_LO_LIMIT[30:0])) begin
                  res_ff   <= osrs_pkg::POS_ZERO;
                  done_ff  <= 1'b1;
                  phase_ff <= E_IDLE;
               end else begin
                  phase_ff <= E_MHI;
               end
            end
            E_MHI: begin
               phi_ff   <= mant * osrs_pkg::LOG2E_FIX[osrs_pkg::EXP_FRAC:LO_W];
               phase_ff <= E_SHIFT;
            end
            E_SHIFT: begin
               k_ff     <= $signed(t[T_W-1:osrs_pkg::EXP_FRAC]);
               f_ff     <= t[osrs_pkg::EXP_FRAC-1:0];
               y_ff     <= 64'd1 << 62;
               j_ff     <= '0;
               phase_ff <= E_ITER;
            end
            E_ITER: begin
               // Greedy split of the fraction over log2(1 + 2^-j).
               if (take) begin
                  f_ff <= f_ff - tbl[j_ff];
                  y_ff <= y_ff + (y_ff >> step);
               end
               j_ff <= step;
               if (j_ff == osrs_pkg::STEP_W'(osrs_pkg::EXP_STEPS - 1)) begin
                  phase_ff <= E_PACK;
               end
            end
            E_PACK: begin
               res_ff   <= osrs_pkg::fp_pack(1'b0, {{3{k_ff[8]}}, k_ff},
                                             {y_ff[62:0], 1'b0}, 1'b0);
               done_ff  <= 1'b1;
               phase_ff <= E_IDLE;
            end
            default: begin
               phase_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ===== src/osrs_datapath.sv =====
// Datapath: row state registers, operand registers, the fp unit and the exp unit.
`timescale 1ns / 1ps
`default_nettype none

module osrs_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire osrs_pkg::dp_cmd_type    cmd,
   input  wire osrs_pkg::req_type       req_item,
   output osrs_pkg::dp_status_type      status,
   output osrs_pkg::rsp_type            rsp_item
);

   osrs_pkg::req_type item_ff;
   osrs_pkg::rsp_type rsp_ff;
   logic [31:0]       max_ff;
   logic [31:0]       sum_ff;
   logic              started_ff;
   logic [31:0]       newmax_ff;
   logic [31:0]       scaled_ff;

   logic              fpu_start, fpu_done;
   osrs_pkg::fop_type fpu_op;
   logic [31:0]       fpu_a, fpu_b, fpu_res;
   logic              exp_start, exp_done;
   logic [31:0]       exp_x, exp_res;

   always_comb begin
      fpu_start = 1'b0;
      fpu_op    = osrs_pkg::FOP_ADD;
      fpu_a     = scaled_ff;
      fpu_b     = exp_res;
      exp_start = 1'b0;
      exp_x     = fpu_res;
      case (cmd.op)
         osrs_pkg::DP_SUB_OLD: begin
            fpu_start = 1'b1;
            fpu_op    = osrs_pkg::FOP_SUB;
            fpu_a     = max_ff;
            fpu_b     = newmax_ff;
         end
         osrs_pkg::DP_SUB_NEW: begin
            fpu_start = 1'b1;
            fpu_op    = osrs_pkg::FOP_SUB;
            fpu_a     = item_ff.score_bits;
            fpu_b     = newmax_ff;
         end
         osrs_pkg::DP_MUL: begin
            fpu_start = 1'b1;
            fpu_op    = osrs_pkg::FOP_MUL;
            fpu_a     = exp_res;
            fpu_b     = sum_ff;
         end
         osrs_pkg::DP_ADD: begin
            fpu_start = 1'b1;
         end
         osrs_pkg::DP_EXP_DIFF: begin
            exp_start = 1'b1;
         end
         osrs_pkg::DP_EXP_MAX: begin
            exp_start = 1'b1;
            exp_x     = max_ff;
         end
         default: begin
         end
      endcase
   end

   osrs_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (fpu_start),
      .op     (fpu_op),
      .a      (fpu_a),
      .b      (fpu_b),
      .done   (fpu_done),
      .result (fpu_res)
   );

   osrs_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .start  (exp_start),
      .x      (exp_x),
      .done   (exp_done),
      .result (exp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= osrs_pkg::NEG_INF;
         sum_ff     <= osrs_pkg::POS_ZERO;
         started_ff <= 1'b0;
      end else begin
         case (cmd.op)
            osrs_pkg::DP_COMMIT: begin
               max_ff     <= newmax_ff;
               sum_ff     <= fpu_res;
               started_ff <= 1'b1;
            end
            osrs_pkg::DP_EMIT: begin
               max_ff     <= osrs_pkg::NEG_INF;
               sum_ff     <= osrs_pkg::POS_ZERO;
               started_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
      case (cmd.op)
         osrs_pkg::DP_LOAD: begin
            item_ff   <= req_item;
            newmax_ff <= osrs_pkg::fp_maxnum(max_ff, req_item.score_bits);
         end
         osrs_pkg::DP_ZERO_SCALED: begin
            scaled_ff <= osrs_pkg::POS_ZERO;
         end
         osrs_pkg::DP_TAKE_SCALED: begin
            scaled_ff <= fpu_res;
         end
         osrs_pkg::DP_EMIT: begin
            rsp_ff.exp_of_max_bits  <= exp_res;
            rsp_ff.denominator_bits <= sum_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.fpu_done    = fpu_done;
   assign status.exp_done    = exp_done;
   assign status.row_started = started_ff;
   assign status.last_in_row = item_ff.last_in_row;
   assign rsp_item           = rsp_ff;

endmodule

`default_nettype wire

// ===== src/osrs_ctrl.sv =====
// Controller state machine that sequences the datapath for each item.
`timescale 1ns / 1ps
`default_nettype none

module osrs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire osrs_pkg::dp_status_type status,
   output osrs_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK,
      S_W_SUB1,
      S_W_EXP1,
      S_W_MUL,
      S_SUB2,
      S_W_SUB2,
      S_W_EXP2,
      S_W_ADD,
      S_EXPMAX,
      S_W_EXP3,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = osrs_pkg::DP_NONE;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = osrs_pkg::DP_LOAD;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (status.row_started) begin
               cmd.op   = osrs_pkg::DP_SUB_OLD;
               state_in = S_W_SUB1;
            end else begin
               cmd.op   = osrs_pkg::DP_ZERO_SCALED;
               state_in = S_SUB2;
            end
         end
         S_W_SUB1: begin
            if (status.fpu_done) begin
               cmd.op   = osrs_pkg::DP_EXP_DIFF;
               state_in = S_W_EXP1;
            end
         end
         S_W_EXP1: begin
            if (status.exp_done) begin
               cmd.op   = osrs_pkg::DP_MUL;
               state_in = S_W_MUL;
            end
         end
         S_W_MUL: begin
            if (status.fpu_done) begin
               cmd.op   = osrs_pkg::DP_TAKE_SCALED;
               state_in = S_SUB2;
            end
         end
         S_SUB2: begin
            cmd.op   = osrs_pkg::DP_SUB_NEW;
            state_in = S_W_SUB2;
         end
         S_W_SUB2: begin
            if (status.fpu_done) begin
               cmd.op   = osrs_pkg::DP_EXP_DIFF;
               state_in = S_W_EXP2;
            end
         end
         S_W_EXP2: begin
            if (status.exp_done) begin
               cmd.op   = osrs_pkg::DP_ADD;
               state_in = S_W_ADD;
            end
         end
         S_W_ADD: begin
            if (status.fpu_done) begin
               cmd.op   = osrs_pkg::DP_COMMIT;
               state_in = status.last_in_row ? S_EXPMAX : S_IDLE;
            end
         end
         S_EXPMAX: begin
            cmd.op   = osrs_pkg::DP_EXP_MAX;
            state_in = S_W_EXP3;
         end
         S_W_EXP3: begin
            if (status.exp_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = osrs_pkg::DP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/online_softmax_row_stats_top.sv =====
// Top level of the online softmax row statistics block.
// Items are handled one at a time; a row's first item skips rescaling the old sum, and
// the last item of a row adds exp of the maximum before its result item is shown.
// A new item is taken only after the last one is through; each exp runs through
// the 56-step shift-and-add loop of the exp unit, and each fp operation through the fp unit.
// Reset (synchronous, active high) sets the maximum to minus infinity, the sum to zero
// and clears the row-started flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module online_softmax_row_stats_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire osrs_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output osrs_pkg::rsp_type      rsp_item
);

   // The controller only issues one datapath command per cycle and reads back
   // the done pulses of the fp and exp units.
   osrs_pkg::dp_cmd_type    cmd;
   osrs_pkg::dp_status_type status;

   osrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register in the datapath holds a finished item until it is taken,
   // while the next items of the following row are already being worked on.
   osrs_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// ===== src/osrs_checker.sv =====
// Port-level checker for the online softmax row statistics block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module osrs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire osrs_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire osrs_pkg::rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is at work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result item appeared right after an accept");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid set right after reset");

endmodule

bind online_softmax_row_stats_top osrs_checker u_osrs_checker (.*);

`default_nettype wire

// ===== tb/online_softmax_row_stats_top_tb.sv =====
// Self-checking testbench for the online softmax row statistics block.
`timescale 1ns / 1ps

module online_softmax_row_stats_top_tb;

   // A score waiting to be sent; wait_idle holds it back until all
   // expected row results have arrived.
   typedef struct {
      osrs_pkg::req_type item;
      bit                wait_idle;
   } pending_score_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   osrs_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   osrs_pkg::rsp_type rsp_item;

   pending_score_type pending_scores[$];
   osrs_pkg::rsp_type expected_stats[$];
   int                mismatch_count = 0;
   int                send_gap = 0;
   int                recv_stall = 0;
   int                sent_count = 0;
   bit                burst_mode = 1'b0;

   // Running row state of the predictor.
   logic [31:0] pred_max = osrs_pkg::NEG_INF;
   logic [31:0] pred_sum = osrs_pkg::POS_ZERO;
   bit          pred_started = 1'b0;

   online_softmax_row_stats_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Widen an fp32 pattern to a double exactly; NaNs keep sign and payload
   // and come out quiet, as a hardware widening would.
   function automatic real f32_to_real(input logic [31:0] b);
      logic [10:0] e;
      if (b[30:23] == 8'hFF) begin
         return $bitstoreal({b[31], 11'h7FF, b[22] | (b[21:0] != 0), b[21:0], 29'd0});
      end
      if (b[30:23] == 8'd0) begin
         // Subnormal or zero: mantissa times 2^-149, then the sign.
         if (b[31]) begin
            return -(real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0}));
         end
         return real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
      end
      e = 11'(b[30:23]) + 11'd896;
      return $bitstoreal({b[31], e, b[22:0], 29'd0});
   endfunction

   // Round a double to fp32, nearest even, with subnormals and overflow.
   function automatic logic [31:0] real_to_f32(input real d);
      logic [63:0]  b;
      logic [52:0]  sig;
      logic [127:0] w;
      logic [31:0]  q;
      logic         rnd;
      int           ex;
      int           sh;
      b = $realtobits(d);
      if (b[62:52] == 11'h7FF) begin
         if (b[51:0] != 0) begin
            return {b[63], 8'hFF, 1'b1, b[50:29]};
         end
         return {b[63], osrs_pkg::POS_INF[30:0]};
      end
      if (b[62:52] == 11'd0) begin
         return {b[63], 31'd0};
      end
      ex  = int'(b[62:52]) - 1023;
      sig = {1'b1, b[51:0]};
      if (ex > 127) begin
         return {b[63], osrs_pkg::POS_INF[30:0]};
      end
      if (ex >= -126) begin
         q   = {1'b0, 8'(ex + 127), b[51:29]};
         rnd = b[28] & ((b[27:0] != 0) | b[29]);
         q   = q + 32'(rnd);
         return {b[63], q[30:0]};
      end
      // Subnormal range: count in units of 2^-149.
      sh  = -(ex + 97);
      if (sh > 120) begin
         sh = 120;
      end
      w   = {11'd0, sig, 64'd0} >> sh;
      q   = w[95:64];
      rnd = w[63] & ((w[62:0] != 0) | q[0]);
      q   = q + 32'(rnd);
      return {b[63], q[30:0]};
   endfunction

   function automatic bit f32_is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 0);
   endfunction

   // maxnum with plus zero ranked above minus zero and NaN operands losing.
   function automatic logic [31:0] f32_maxnum(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a)) begin
         return f32_is_nan(b) ? a : b;
      end
      if (f32_is_nan(b)) begin
         return a;
      end
      if (f32_to_real(a) == f32_to_real(b)) begin
         return a[31] ? b : a;
      end
      return (f32_to_real(a) > f32_to_real(b)) ? a : b;
   endfunction

   function automatic real pow2_real(input int k);
      logic [31:0] e;
      e = k + 1023;
      return $bitstoreal({1'b0, e[10:0], 52'd0});
   endfunction

   // fp32 exp: range reduction by ln2, Taylor series in double, one rounding.
   function automatic logic [31:0] f32_exp(input logic [31:0] xb);
      real xd;
      real t;
      real r;
      real acc;
      real term;
      real d;
      int  k;
      if (f32_is_nan(xb)) begin
         return xb | osrs_pkg::QUIET_BIT;
      end
      xd = f32_to_real(xb);
      if (xd > 89.0) begin
         return osrs_pkg::POS_INF;
      end
      if (xd < -104.0) begin
         return osrs_pkg::POS_ZERO;
      end
      t    = xd * 1.4426950408889634;
      k    = $rtoi(t + ((t < 0.0) ? -0.5 : 0.5));
      r    = xd - real'(k) * 6.93147180369123816490e-01;
      r    = r - real'(k) * 1.90821492927058770002e-10;
      acc  = 1.0;
      term = 1.0;
      for (int n = 1; n <= 13; n++) begin
         term = term * r / real'(n);
         acc  = acc + term;
      end
      d = acc * pow2_real(k / 2) * pow2_real(k - k / 2);
      if (d >= 3.4028235677973366e38) begin
         return osrs_pkg::POS_INF;
      end
      return real_to_f32(d);
   endfunction

   // Fold one accepted score into the running row state and queue the row
   // statistics when the score closes the row.
   task automatic fold_score(input osrs_pkg::req_type it);
      logic [31:0]       new_max;
      logic [31:0]       scaled;
      logic [31:0]       fresh;
      logic [31:0]       diff;
      logic [31:0]       sum;
      osrs_pkg::rsp_type stats;
      new_max = f32_maxnum(pred_max, it.score_bits);
      if (pred_started) begin
         diff   = real_to_f32(f32_to_real(pred_max) - f32_to_real(new_max));
         scaled = real_to_f32(f32_to_real(f32_exp(diff)) * f32_to_real(pred_sum));
      end else begin
         // The first element of a row drops the old sum entirely.
         scaled = real_to_f32(0.0 * f32_to_real(pred_sum));
      end
      diff     = real_to_f32(f32_to_real(it.score_bits) - f32_to_real(new_max));
      fresh    = f32_exp(diff);
      sum      = real_to_f32(f32_to_real(scaled) + f32_to_real(fresh));
      pred_max = new_max;
      pred_sum = sum;
      pred_started = 1'b1;
      if (it.last_in_row) begin
         stats.exp_of_max_bits  = f32_exp(new_max);
         stats.denominator_bits = sum;
         expected_stats.push_back(stats);
         pred_max     = osrs_pkg::NEG_INF;
         pred_sum     = osrs_pkg::POS_ZERO;
         pred_started = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_score(input logic [31:0] bits, input bit last, input bit wait_idle);
      pending_score_type p;
      p.item.score_bits  = bits;
      p.item.last_in_row = last;
      p.wait_idle        = wait_idle;
      pending_scores.push_back(p);
   endtask

   // A well-formed score: moderate magnitude, random sign and mantissa.
   function automatic logic [31:0] moderate_score();
      return {1'($urandom), 8'($urandom_range(118, 133)), 23'($urandom)};
   endfunction

   // Driver: presents pending scores with a random gap per item outside burst mode. The scores
   // are predicted at the edge where they are accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            fold_score(req_item);
            sent_count++;
            if (sent_count % 97 == 0) begin
               burst_mode = ~burst_mode;
            end
            send_gap = burst_mode ? 0 : $urandom_range(0, 6);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_scores.size() > 0 &&
                         !(pending_scores[0].wait_idle && expected_stats.size() > 0)) begin
               req_item  <= pending_scores[0].item;
               req_valid <= 1'b1;
               void'(pending_scores.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls the result side at random outside burst mode and checks every result item
   // against the oldest expected row statistics.
   always @(posedge clock) begin
      osrs_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected result", rsp_item.denominator_bits, '0);
            end else begin
               want = expected_stats.pop_front();
               if (rsp_item.exp_of_max_bits !== want.exp_of_max_bits) begin
                  report_mismatch("exp_of_max", rsp_item.exp_of_max_bits,
                                  want.exp_of_max_bits);
               end
               if (rsp_item.denominator_bits !== want.denominator_bits) begin
                  report_mismatch("denominator", rsp_item.denominator_bits,
                                  want.denominator_bits);
               end
            end
            recv_stall = burst_mode ? 0 : $urandom_range(0, 6);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int row_len;
      // Directed rows: one element, ascending scores, NaN in the middle,
      // a row of only NaN, signed zeros, all minus infinity, plus infinity,
      // exp overflow and underflow, subnormal against the largest finite,
      // and a NaN leading the row.
      queue_score(32'h0000_0000, 1'b1, 1'b0);
      queue_score(32'h3F80_0000, 1'b0, 1'b0);
      queue_score(32'h4000_0000, 1'b0, 1'b0);
      queue_score(32'h4040_0000, 1'b1, 1'b0);
      queue_score(32'h3F80_0000, 1'b0, 1'b0);
      queue_score(32'h7FC0_0001, 1'b0, 1'b0);
      queue_score(32'h4000_0000, 1'b1, 1'b0);
      queue_score(32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_score(32'h8000_0000, 1'b0, 1'b0);
      queue_score(32'h0000_0000, 1'b1, 1'b0);
      queue_score(32'hFF80_0000, 1'b0, 1'b0);
      queue_score(32'hFF80_0000, 1'b1, 1'b0);
      queue_score(32'h7F80_0000, 1'b1, 1'b0);
      queue_score(32'h42C8_0000, 1'b1, 1'b0);
      queue_score(32'hC348_0000, 1'b0, 1'b0);
      queue_score(32'hBF80_0000, 1'b1, 1'b0);
      queue_score(32'h0000_0001, 1'b0, 1'b0);
      queue_score(32'h7F7F_FFFF, 1'b1, 1'b0);
      queue_score(32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_score(32'h3F80_0000, 1'b1, 1'b0);

      // Random rows, mostly of moderate scores; some raw bit patterns. The first random
      // item, and a row's first item at queue position 600 if any, wait for the block to drain.
      while (pending_scores.size() < 1170) begin
         row_len = $urandom_range(1, 8);
         for (int i = 0; i < row_len; i++) begin
            queue_score(($urandom_range(0, 9) == 0) ? 32'($urandom) : moderate_score(),
                        i == row_len - 1,
                        (pending_scores.size() == 20) || (pending_scores.size() == 600 && i == 0));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_scores.size() > 0 || req_valid || expected_stats.size() > 0) begin
         @(posedge clock);
      end
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_stats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hung block: several times the slowest correct run.
   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
